>>> design/si_pkg.sv
// Package for segment_intersection: widths, stage counts and the divider
// cell payload type. No dependencies.
package si_pkg;
  localparam int COORD_W = 16;
  localparam int COORD_FRAC_BITS = 4;
  localparam int QUOTIENT_FRAC_BITS = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int REM_W = CROSS_W;
  localparam int CELL_COUNT = QUOTIENT_FRAC_BITS + 1;
  localparam int QUO_W = CELL_COUNT;
  localparam int SCALE_W = QUO_W + 1 + DIFF_W;
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES = 2;
  localparam int STAGES = FRONT_STAGES + CELL_COUNT + BACK_STAGES;
  localparam int UNIT = 1 << (2 * COORD_FRAC_BITS);

  typedef struct packed {
    logic                      hit;
    logic [REM_W-1:0]          rem;
    logic [REM_W-1:0]          dvsr;
    logic [QUO_W-1:0]          quo;
    logic signed [COORD_W-1:0] p1x;
    logic signed [COORD_W-1:0] p1y;
    logic signed [DIFF_W-1:0]  d1x;
    logic signed [DIFF_W-1:0]  d1y;
  } si_cell_t;
endpackage

>>> design/si_front.sv
// Front stages of segment_intersection: differences, cross products and the
// hit decision, feeding the divider chain. Depends on si_pkg.
module si_front (
  input  logic                              clk,
  input  logic [si_pkg::FRONT_STAGES-1:0]   ld,
  input  logic signed [si_pkg::COORD_W-1:0] p1x_in,
  input  logic signed [si_pkg::COORD_W-1:0] p1y_in,
  input  logic signed [si_pkg::COORD_W-1:0] p2x_in,
  input  logic signed [si_pkg::COORD_W-1:0] p2y_in,
  input  logic signed [si_pkg::COORD_W-1:0] q1x_in,
  input  logic signed [si_pkg::COORD_W-1:0] q1y_in,
  input  logic signed [si_pkg::COORD_W-1:0] q2x_in,
  input  logic signed [si_pkg::COORD_W-1:0] q2y_in,
  output si_pkg::si_cell_t                  cell_out
);
  import si_pkg::*;

  logic signed [COORD_W-1:0] p1x1, p1y1, p1x2, p1y2, p1x3, p1y3;
  logic signed [DIFF_W-1:0]  d1x1, d1y1, d2x1, d2y1, wx1, wy1;
  logic signed [DIFF_W-1:0]  d1x2, d1y2, d1x3, d1y3;
  logic signed [PROD_W-1:0]  pd, pe, ps1, ps2, pt1, pt2;
  logic signed [CROSS_W-1:0] denom, s_num, t_num;
  logic signed [CROSS_W-1:0] mag, t_mag;
  logic                      pos, hit;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p1x1 <= p1x_in;
      p1y1 <= p1y_in;
      d1x1 <= {p2x_in[COORD_W-1], p2x_in} - {p1x_in[COORD_W-1], p1x_in};
      d1y1 <= {p2y_in[COORD_W-1], p2y_in} - {p1y_in[COORD_W-1], p1y_in};
      d2x1 <= {q2x_in[COORD_W-1], q2x_in} - {q1x_in[COORD_W-1], q1x_in};
      d2y1 <= {q2y_in[COORD_W-1], q2y_in} - {q1y_in[COORD_W-1], q1y_in};
      wx1  <= {p1x_in[COORD_W-1], p1x_in} - {q1x_in[COORD_W-1], q1x_in};
      wy1  <= {p1y_in[COORD_W-1], p1y_in} - {q1y_in[COORD_W-1], q1y_in};
    end
    if (ld[1]) begin
      p1x2 <= p1x1;
      p1y2 <= p1y1;
      d1x2 <= d1x1;
      d1y2 <= d1y1;
      pd   <= d1x1 * d2y1;
      pe   <= d2x1 * d1y1;
      ps1  <= d1x1 * wy1;
      ps2  <= d1y1 * wx1;
      pt1  <= d2x1 * wy1;
      pt2  <= d2y1 * wx1;
    end
    if (ld[2]) begin
      p1x3  <= p1x2;
      p1y3  <= p1y2;
      d1x3  <= d1x2;
      d1y3  <= d1y2;
      denom <= {pd[PROD_W-1], pd} - {pe[PROD_W-1], pe};
      s_num <= {ps1[PROD_W-1], ps1} - {ps2[PROD_W-1], ps2};
      t_num <= {pt1[PROD_W-1], pt1} - {pt2[PROD_W-1], pt2};
    end
    if (ld[3]) begin
      cell_out.hit  <= hit;
      cell_out.rem  <= hit ? t_mag : '0;
      cell_out.dvsr <= {mag[REM_W-2:0], 1'b0};
      cell_out.quo  <= '0;
      cell_out.p1x  <= p1x3;
      cell_out.p1y  <= p1y3;
      cell_out.d1x  <= d1x3;
      cell_out.d1y  <= d1y3;
    end
  end

  always_comb begin
    mag   = denom[CROSS_W-1] ? -denom : denom;
    t_mag = t_num[CROSS_W-1] ? -t_num : t_num;
    pos   = !denom[CROSS_W-1] && (denom != '0);
    hit   = 1'b1;
    if (mag < CROSS_W'(UNIT)) begin
      hit = 1'b0;
    end else if (((s_num < 0) == pos) || ((t_num < 0) == pos)) begin
      hit = 1'b0;
    end else if (((s_num > denom) == pos) || ((t_num > denom) == pos)) begin
      hit = 1'b0;
    end
  end
endmodule

>>> design/si_div_cell.sv
// One restoring-division cell of segment_intersection: produces one quotient
// bit and hands the partial remainder on. Depends on si_pkg.
module si_div_cell (
  input  logic             clk,
  input  logic             ld,
  input  si_pkg::si_cell_t cell_in,
  output si_pkg::si_cell_t cell_out
);
  import si_pkg::*;

  logic [REM_W:0] dbl, dif;
  logic           ge;
  si_cell_t       cell_next;

  always_comb begin
    dbl = {cell_in.rem, 1'b0};
    dif = dbl - {1'b0, cell_in.dvsr};
    ge  = dbl >= {1'b0, cell_in.dvsr};
    cell_next      = cell_in;
    cell_next.rem  = ge ? dif[REM_W-1:0] : dbl[REM_W-1:0];
    cell_next.quo  = {cell_in.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      cell_out <= cell_next;
    end
  end
endmodule

>>> design/si_back.sv
// Back stages of segment_intersection: scale the direction by the quotient
// and add the start point; coordinates are zero on a miss. Depends on si_pkg.
module si_back (
  input  logic                              clk,
  input  logic [si_pkg::BACK_STAGES-1:0]    ld,
  input  si_pkg::si_cell_t                  cell_in,
  output logic                              hit,
  output logic signed [si_pkg::COORD_W-1:0] cross_x,
  output logic signed [si_pkg::COORD_W-1:0] cross_y
);
  import si_pkg::*;

  logic                      hit1;
  logic signed [COORD_W-1:0] p1x1, p1y1;
  logic signed [SCALE_W-1:0] sx, sy, ax, ay;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      hit1 <= cell_in.hit;
      p1x1 <= cell_in.p1x;
      p1y1 <= cell_in.p1y;
      sx   <= $signed({1'b0, cell_in.quo}) * cell_in.d1x;
      sy   <= $signed({1'b0, cell_in.quo}) * cell_in.d1y;
    end
    if (ld[1]) begin
      hit     <= hit1;
      cross_x <= hit1 ? p1x1 + ax[QUOTIENT_FRAC_BITS+COORD_W-1:QUOTIENT_FRAC_BITS] : '0;
      cross_y <= hit1 ? p1y1 + ay[QUOTIENT_FRAC_BITS+COORD_W-1:QUOTIENT_FRAC_BITS] : '0;
    end
  end

  always_comb begin
    ax = sx + (sx[SCALE_W-1] ? SCALE_W'((1 << QUOTIENT_FRAC_BITS) - 1) : '0);
    ay = sy + (sy[SCALE_W-1] ? SCALE_W'((1 << QUOTIENT_FRAC_BITS) - 1) : '0);
  end
endmodule

>>> design/segment_intersection.sv
// Segment intersection by cross products, one segment pair per transfer.
// Pipeline: 4 front stages, 17 divider cells, 2 output stages. Throughput:
// one pair per cycle unless m_tready back-pressure stalls the pipeline; each
// stage loads whenever it is empty or its successor moves.
// Reset: rst (synchronous) clears all stage valid flags; data is not reset.
module segment_intersection (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // other_start_x, other_start_y, other_end_x, other_end_y
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cross_x, cross_y
  output logic [31:0]  m_tdata,
  // hit
  output logic         m_tuser
);
  import si_pkg::*;

  logic [STAGES-1:0]   v, ld;
  si_cell_t            chain [CELL_COUNT+1];
  logic signed [COORD_W-1:0] cx, cy;

  always_comb begin
    ld[STAGES-1] = !v[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (ld[k]) begin
          v[k] <= (k == 0) ? s_tvalid : v[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  si_front u_front (
    .clk      (clk),
    .ld       (ld[FRONT_STAGES-1:0]),
    .p1x_in   (s_tdata[15:0]),
    .p1y_in   (s_tdata[31:16]),
    .p2x_in   (s_tdata[47:32]),
    .p2y_in   (s_tdata[63:48]),
    .q1x_in   (s_tdata[79:64]),
    .q1y_in   (s_tdata[95:80]),
    .q2x_in   (s_tdata[111:96]),
    .q2y_in   (s_tdata[127:112]),
    .cell_out (chain[0])
  );

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    si_div_cell u_cell (
      .clk      (clk),
      .ld       (ld[FRONT_STAGES+i]),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  si_back u_back (
    .clk     (clk),
    .ld      (ld[STAGES-1:STAGES-BACK_STAGES]),
    .cell_in (chain[CELL_COUNT]),
    .hit     (m_tuser),
    .cross_x (cx),
    .cross_y (cy)
  );

  assign s_tready = ld[0];
  assign m_tvalid = v[STAGES-1];
  assign m_tdata  = {cy, cx};
endmodule
